FILE: sv/rvd_pkg.sv
// ----------------------------------------------------------------------------
// RV32I + RVC decoder package
// Operation kinds, and opcode and field constants shared by the decoder and its
// checker, and the funct3 lookup functions used by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rvd_pkg;

  // Port widths.
  localparam int WORD_W = 32;
  localparam int KIND_W = 6;
  localparam int REG_W  = 5;
  localparam int STEP_W = 3;

  // Dense operation kinds, numbered from zero in this order.
  typedef enum logic [KIND_W-1:0] {
    K_UNSUP, K_LUI, K_AUIPC,
    K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI,
    K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
    K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU, K_JAL, K_JALR,
    K_CSRRW, K_CSRRS, K_CSRRC, K_CSRRWI, K_CSRRSI, K_CSRRCI,
    K_ECALL, K_EBREAK, K_MRET, K_SRET, K_SFENCE_VMA,
    K_LB, K_LH, K_LW, K_LBU, K_LHU, K_SB, K_SH, K_SW
  } op_kind_t;

  // Program counter steps.
  localparam logic [STEP_W-1:0] STEP_FULL  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SHORT = 3'd2;
  localparam logic [STEP_W-1:0] STEP_NONE  = 3'd0;

  // Full-width major opcodes.
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;

  // Quadrant codes in the low two bits: full width and the three compressed quadrants.
  localparam logic [1:0] QUAD_FULL = 2'b11;
  localparam logic [1:0] QUAD_C0   = 2'b00;
  localparam logic [1:0] QUAD_C1   = 2'b01;
  localparam logic [1:0] QUAD_C2   = 2'b10;

  // Funct7 and system function codes.
  localparam logic [6:0]  F7_ALT    = 7'h20;
  localparam logic [6:0]  F7_SFENCE = 7'h09;
  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;
  localparam logic [11:0] SYS_SRET   = 12'h102;
  localparam logic [11:0] SYS_MRET   = 12'h302;

  // Register numbers used by compressed forms.
  localparam logic [REG_W-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_W-1:0] REG_SP   = 5'd2;

  function automatic op_kind_t opimm_kind(input logic [2:0] f3);
    op_kind_t k;
    case (f3)
      3'd0: k = K_ADDI;
      3'd1: k = K_SLLI;
      3'd2: k = K_SLTI;
      3'd3: k = K_SLTIU;
      3'd4: k = K_XORI;
      3'd5: k = K_SRLI;
      3'd6: k = K_ORI;
      default: k = K_ANDI;
    endcase
    return k;
  endfunction

  function automatic op_kind_t op_kind_of(input logic [2:0] f3);
    op_kind_t k;
    case (f3)
      3'd0: k = K_ADD;
      3'd1: k = K_SLL;
      3'd2: k = K_SLT;
      3'd3: k = K_SLTU;
      3'd4: k = K_XOR;
      3'd5: k = K_SRL;
      3'd6: k = K_OR;
      default: k = K_AND;
    endcase
    return k;
  endfunction

  function automatic op_kind_t branch_kind(input logic [2:0] f3);
    op_kind_t k;
    case (f3)
      3'd0: k = K_BEQ;
      3'd1: k = K_BNE;
      3'd4: k = K_BLT;
      3'd5: k = K_BGE;
      3'd6: k = K_BLTU;
      3'd7: k = K_BGEU;
      default: k = K_UNSUP;
    endcase
    return k;
  endfunction

  function automatic op_kind_t csr_kind(input logic [2:0] f3);
    op_kind_t k;
    case (f3)
      3'd1: k = K_CSRRW;
      3'd2: k = K_CSRRS;
      3'd3: k = K_CSRRC;
      3'd5: k = K_CSRRWI;
      3'd6: k = K_CSRRSI;
      3'd7: k = K_CSRRCI;
      default: k = K_UNSUP;
    endcase
    return k;
  endfunction

  function automatic op_kind_t load_kind(input logic [2:0] f3);
    op_kind_t k;
    case (f3)
      3'd0: k = K_LB;
      3'd1: k = K_LH;
      3'd2: k = K_LW;
      3'd4: k = K_LBU;
      3'd5: k = K_LHU;
      default: k = K_UNSUP;
    endcase
    return k;
  endfunction

  function automatic op_kind_t store_kind(input logic [2:0] f3);
    op_kind_t k;
    case (f3)
      3'd0: k = K_SB;
      3'd1: k = K_SH;
      3'd2: k = K_SW;
      default: k = K_UNSUP;
    endcase
    return k;
  endfunction

  // Register-register compressed arithmetic, selected by bits [6:5].
  function automatic op_kind_t c_arith_kind(input logic [1:0] sel);
    op_kind_t k;
    case (sel)
      2'd0: k = K_SUB;
      2'd1: k = K_XOR;
      2'd2: k = K_OR;
      default: k = K_AND;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rv32i_rvc_instruction_decoder.sv
// ----------------------------------------------------------------------------
// RV32I + RVC instruction decoder
// Decodes one fetched word per transfer into operation kind, register
// numbers, immediate, pc step and raw word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_ready / instr_word) takes one fetched
//   word per transfer. A word whose low two bits are not 11 is decoded as a
//   compressed instruction from its low 16 bits.
//   The output channel (out_valid / out_ready and the decoded fields) gives
//   one decoded record per input transfer, in order.
//   The word is captured in an input register, then decoded by shallow
//   field logic into the result register. Throughput is one word per
//   cycle while out_ready is high; a stalled receiver holds the flow.
//   When the receiver stalls, the result register holds its record and the
//   input register still takes one more word; in_ready falls only when
//   both registers are full and out_ready is low.
//   Synchronous reset empties both registers; no record is presented after
//   reset until a new word is transferred in.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_rvc_instruction_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rvd_pkg::WORD_W-1:0]    instr_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rvd_pkg::KIND_W-1:0]         op_kind,
  output logic [rvd_pkg::REG_W-1:0]          dest_reg,
  output logic [rvd_pkg::REG_W-1:0]          src1_reg,
  output logic [rvd_pkg::REG_W-1:0]          src2_reg,
  output logic signed [rvd_pkg::WORD_W-1:0]  immediate,
  output logic [rvd_pkg::STEP_W-1:0]         pc_advance,
  output logic [rvd_pkg::WORD_W-1:0]         raw_word
);

  import rvd_pkg::*;

  // Input register.
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic              out_load;

  // Decode results.
  op_kind_t          dec_kind;
  logic [REG_W-1:0]  dec_rd;
  logic [REG_W-1:0]  dec_rs1;
  logic [REG_W-1:0]  dec_rs2;
  logic [WORD_W-1:0] dec_imm;
  logic [STEP_W-1:0] dec_step;
  logic [WORD_W-1:0] dec_raw;

  // Field views of the captured word.
  logic [6:0]        opc;
  logic [2:0]        f3;
  logic [6:0]        f7;
  logic [WORD_W-1:0] iimm;
  logic [2:0]        cf3;
  logic [REG_W-1:0]  c_rdf;
  logic [REG_W-1:0]  c_lo5;
  logic [REG_W-1:0]  c_rdp;
  logic [REG_W-1:0]  c_rsp;
  logic              c_b12;
  logic [WORD_W-1:0] c_imm6;
  logic [9:0]        c_uimm;
  logic [9:0]        c_sp16;

  // Handshake: the input register moves on whenever the result register
  // is empty or being drained.
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= instr_word;
    end
  end

  // Field extraction.
  assign opc    = s1_word[6:0];
  assign f3     = s1_word[14:12];
  assign f7     = s1_word[31:25];
  assign iimm   = {{20{s1_word[31]}}, s1_word[31:20]};
  assign cf3    = s1_word[15:13];
  assign c_rdf  = s1_word[11:7];
  assign c_lo5  = s1_word[6:2];
  assign c_b12  = s1_word[12];
  assign c_rdp  = {2'b01, s1_word[9:7]};
  assign c_rsp  = {2'b01, s1_word[4:2]};
  assign c_imm6 = {{26{s1_word[12]}}, s1_word[12], s1_word[6:2]};
  assign c_uimm = {s1_word[10:7], s1_word[12:11], s1_word[5], s1_word[6], 2'b00};
  assign c_sp16 = {s1_word[12], s1_word[4:3], s1_word[5], s1_word[2], s1_word[6], 4'b0000};

  // Decode of the captured word.
  always_comb begin
    if (s1_word[1:0] != QUAD_FULL) begin
      // Compressed: kind, registers and immediate zero unless a supported form matches.
      dec_kind = K_UNSUP;
      dec_rd   = REG_ZERO;
      dec_rs1  = REG_ZERO;
      dec_rs2  = REG_ZERO;
      dec_imm  = '0;
      dec_step = STEP_SHORT;
      dec_raw  = {16'h0000, s1_word[15:0]};
      case (s1_word[1:0])
        QUAD_C0: begin
          // C.ADDI4SPN.
          if (cf3 == 3'd0 && c_uimm != 10'd0) begin
            dec_kind = K_ADDI;
            dec_rd   = c_rsp;
            dec_rs1  = REG_SP;
            dec_imm  = {22'd0, c_uimm};
          end
        end
        QUAD_C1: begin
          case (cf3)
            3'd0, 3'd2: begin
              // C.NOP, C.ADDI and C.LI.
              if (c_rdf != REG_ZERO) begin
                dec_kind = K_ADDI;
                dec_rd   = c_rdf;
                dec_rs1  = (cf3 == 3'd0) ? c_rdf : REG_ZERO;
                dec_imm  = c_imm6;
              end else if (cf3 == 3'd0 && {c_b12, c_lo5} == 6'd0) begin
                dec_kind = K_ADDI;
              end
            end
            3'd3: begin
              // C.ADDI16SP and C.LUI.
              if (c_rdf == REG_SP) begin
                if (c_sp16 != 10'd0) begin
                  dec_kind = K_ADDI;
                  dec_rd   = REG_SP;
                  dec_rs1  = REG_SP;
                  dec_imm  = {{22{c_sp16[9]}}, c_sp16};
                end
              end else if (c_rdf != REG_ZERO && {c_b12, c_lo5} != 6'd0) begin
                dec_kind = K_LUI;
                dec_rd   = c_rdf;
                dec_imm  = {{14{c_b12}}, c_b12, c_lo5, 12'h000};
              end
            end
            3'd4: begin
              // Shifts, C.ANDI and register-register arithmetic.
              case (s1_word[11:10])
                2'd0, 2'd1: begin
                  if (!c_b12) begin
                    dec_kind = s1_word[10] ? K_SRAI : K_SRLI;
                    dec_rd   = c_rdp;
                    dec_rs1  = c_rdp;
                    dec_imm  = {27'd0, c_lo5};
                  end
                end
                2'd2: begin
                  dec_kind = K_ANDI;
                  dec_rd   = c_rdp;
                  dec_rs1  = c_rdp;
                  dec_imm  = c_imm6;
                end
                default: begin
                  if (!c_b12) begin
                    dec_kind = c_arith_kind(s1_word[6:5]);
                    dec_rd   = c_rdp;
                    dec_rs1  = c_rdp;
                    dec_rs2  = c_rsp;
                  end
                end
              endcase
            end
            default: begin
            end
          endcase
        end
        QUAD_C2: begin
          if (cf3 == 3'd0) begin
            // C.SLLI.
            if (c_rdf != REG_ZERO && !c_b12) begin
              dec_kind = K_SLLI;
              dec_rd   = c_rdf;
              dec_rs1  = c_rdf;
              dec_imm  = {27'd0, c_lo5};
            end
          end else if (cf3 == 3'd4) begin
            // C.MV and C.ADD.
            if (c_lo5 != REG_ZERO && c_rdf != REG_ZERO) begin
              dec_kind = K_ADD;
              dec_rd   = c_rdf;
              dec_rs1  = c_b12 ? c_rdf : REG_ZERO;
              dec_rs2  = c_lo5;
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      // Full width: register fields are always the raw bit fields.
      dec_kind = K_UNSUP;
      dec_rd   = s1_word[11:7];
      dec_rs1  = s1_word[19:15];
      dec_rs2  = s1_word[24:20];
      dec_imm  = '0;
      dec_step = STEP_FULL;
      dec_raw  = s1_word;
      case (opc)
        OPC_LUI: begin
          dec_kind = K_LUI;
          dec_imm  = {s1_word[31:12], 12'h000};
        end
        OPC_AUIPC: begin
          dec_kind = K_AUIPC;
          dec_imm  = {s1_word[31:12], 12'h000};
        end
        OPC_OPIMM: begin
          dec_kind = opimm_kind(f3);
          dec_imm  = iimm;
          if (f3 == 3'd1 || f3 == 3'd5) begin
            dec_imm = {27'd0, s1_word[24:20]};
          end
          if (f3 == 3'd5 && f7 == F7_ALT) begin
            dec_kind = K_SRAI;
          end
        end
        OPC_OP: begin
          dec_kind = op_kind_of(f3);
          if (f7 == F7_ALT && f3 == 3'd0) begin
            dec_kind = K_SUB;
          end
          if (f7 == F7_ALT && f3 == 3'd5) begin
            dec_kind = K_SRA;
          end
        end
        OPC_BRANCH: begin
          dec_kind = branch_kind(f3);
          dec_step = STEP_NONE;
          dec_imm  = {{20{s1_word[31]}}, s1_word[7], s1_word[30:25],
                      s1_word[11:8], 1'b0};
        end
        OPC_JAL: begin
          dec_kind = K_JAL;
          dec_step = STEP_NONE;
          dec_imm  = {{12{s1_word[31]}}, s1_word[19:12], s1_word[20],
                      s1_word[30:21], 1'b0};
        end
        OPC_JALR: begin
          if (f3 == 3'd0) begin
            dec_kind = K_JALR;
            dec_imm  = iimm;
            dec_step = STEP_NONE;
          end
        end
        OPC_SYSTEM: begin
          dec_imm = {20'd0, s1_word[31:20]};
          if (f3 != 3'd0) begin
            dec_kind = csr_kind(f3);
          end else if (f7 == F7_SFENCE) begin
            dec_kind = K_SFENCE_VMA;
          end else if (s1_word[31:20] == SYS_ECALL) begin
            dec_kind = K_ECALL;
            dec_step = STEP_NONE;
          end else if (s1_word[31:20] == SYS_EBREAK) begin
            dec_kind = K_EBREAK;
            dec_step = STEP_NONE;
          end else if (s1_word[31:20] == SYS_MRET) begin
            dec_kind = K_MRET;
            dec_step = STEP_NONE;
          end else if (s1_word[31:20] == SYS_SRET) begin
            dec_kind = K_SRET;
            dec_step = STEP_NONE;
          end
        end
        OPC_LOAD: begin
          dec_kind = load_kind(f3);
          dec_imm  = iimm;
        end
        OPC_STORE: begin
          dec_kind = store_kind(f3);
          dec_imm  = {{20{s1_word[31]}}, s1_word[31:25], s1_word[11:7]};
        end
        default: begin
        end
      endcase
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      op_kind    <= dec_kind;
      dest_reg   <= dec_rd;
      src1_reg   <= dec_rs1;
      src2_reg   <= dec_rs2;
      immediate  <= dec_imm;
      pc_advance <= dec_step;
      raw_word   <= dec_raw;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rvd_checker.sv
// ----------------------------------------------------------------------------
// RV32I + RVC decoder checker
// Port-level assertions on the decoder's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [rvd_pkg::WORD_W-1:0]    instr_word,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rvd_pkg::KIND_W-1:0]    op_kind,
  input wire logic [rvd_pkg::REG_W-1:0]     dest_reg,
  input wire logic [rvd_pkg::REG_W-1:0]     src1_reg,
  input wire logic [rvd_pkg::REG_W-1:0]     src2_reg,
  input wire logic [rvd_pkg::WORD_W-1:0]    immediate,
  input wire logic [rvd_pkg::STEP_W-1:0]    pc_advance,
  input wire logic [rvd_pkg::WORD_W-1:0]    raw_word
);

  import rvd_pkg::*;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented right after reset");

  // A word that waits on the input channel holds still until its transfer.
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(instr_word))
    else $error("waiting input word changed");

  // A stalled record holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(raw_word) && $stable(op_kind)
      && $stable(immediate))
    else $error("stalled result changed");

  // Compressed records carry a zero-extended halfword and a step of two.
  a_short_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && raw_word[1:0] != QUAD_FULL |->
      pc_advance == STEP_SHORT && raw_word[31:16] == 16'h0000)
    else $error("compressed record has wrong step or raw word");

  // Full-width records take register numbers straight from the word.
  a_full_regs: assert property (@(posedge clk) disable iff (rst)
    out_valid && raw_word[1:0] == QUAD_FULL |->
      dest_reg == raw_word[11:7] && src1_reg == raw_word[19:15]
      && src2_reg == raw_word[24:20]
      && (pc_advance == STEP_FULL || pc_advance == STEP_NONE))
    else $error("full-width record has wrong register fields or step");

endmodule

bind rv32i_rvc_instruction_decoder rvd_checker u_rvd_checker (.*);

`default_nettype wire
